// File: hdl/ssi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and constants for the segment intersection pipeline
// Field widths, fixed-point format, result codes and the saturation helper.
// ----------------------------------------------------------------------------
package ssi_pkg;

	localparam int unsigned COORD_WIDTH_DEF = 32;
	localparam int unsigned IN_WIDTH        = 32;
	localparam int unsigned LEN_WIDTH       = 31;
	localparam int unsigned OUT_WIDTH       = 32;
	localparam int unsigned FRAC_BITS       = 16;
	localparam int unsigned QUOT_BITS       = FRAC_BITS + 1;
	localparam int unsigned QUOT_ONE        = 1 << FRAC_BITS;
	localparam int unsigned DIV_STEPS       = 3;
	localparam int unsigned DIV_STAGES      = (QUOT_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int unsigned NUM_STAGES      = 4 + DIV_STAGES + 2;

	typedef enum logic [1:0] {
		HIT_NONE    = 2'd0,
		HIT_POINT   = 2'd1,
		HIT_OVERLAP = 2'd2
	} hit_kind_t;

	typedef struct packed {
		logic signed [IN_WIDTH-1:0] first_start_x;
		logic signed [IN_WIDTH-1:0] first_start_y;
		logic signed [IN_WIDTH-1:0] first_dir_x;
		logic signed [IN_WIDTH-1:0] first_dir_y;
		logic [LEN_WIDTH-1:0]       first_length;
		logic signed [IN_WIDTH-1:0] second_start_x;
		logic signed [IN_WIDTH-1:0] second_start_y;
		logic signed [IN_WIDTH-1:0] second_dir_x;
		logic signed [IN_WIDTH-1:0] second_dir_y;
		logic [LEN_WIDTH-1:0]       second_length;
	} seg_pair_t;

	// status that follows an item from the cross products to the result
	typedef struct packed {
		logic den_zero;
		logic num_zero;
		logic neg_a;
		logic neg_b;
		logic big_a;
		logic big_b;
	} ssi_flags_t;

	// clamp a signed value to a signed field of the given width
	function automatic logic signed [127:0] sat_s(input logic signed [127:0] v,
		input int unsigned bits);
		logic signed [127:0] lim;
		logic signed [127:0] res;
		lim = 128'sd1 <<< (bits - 1);
		if (v > lim - 128'sd1) begin
			res = lim - 128'sd1;
		end else if (v < -lim) begin
			res = -lim;
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

// File: hdl/ssi_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_if: channel interfaces of the segment intersection block
// Segment pair beats in, hit beats out, each with valid and ready.
// ----------------------------------------------------------------------------
interface ssi_pair_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] first_start_x;
	logic signed [31:0] first_start_y;
	logic signed [31:0] first_dir_x;
	logic signed [31:0] first_dir_y;
	logic [30:0]        first_length;
	logic signed [31:0] second_start_x;
	logic signed [31:0] second_start_y;
	logic signed [31:0] second_dir_x;
	logic signed [31:0] second_dir_y;
	logic [30:0]        second_length;

	modport source(output valid, output first_start_x, output first_start_y,
		output first_dir_x, output first_dir_y, output first_length,
		output second_start_x, output second_start_y, output second_dir_x,
		output second_dir_y, output second_length, input ready);
	modport sink(input valid, input first_start_x, input first_start_y,
		input first_dir_x, input first_dir_y, input first_length,
		input second_start_x, input second_start_y, input second_dir_x,
		input second_dir_y, input second_length, output ready);
endinterface

interface ssi_hit_if;
	logic               valid;
	logic               ready;
	logic [1:0]         hit_kind;
	logic signed [31:0] hit_x;
	logic signed [31:0] hit_y;

	modport source(output valid, output hit_kind, output hit_x, output hit_y,
		input ready);
	modport sink(input valid, input hit_kind, input hit_x, input hit_y,
		output ready);
endinterface
`default_nettype wire

// File: hdl/ssi_endpoint.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_endpoint: end points and edge vectors
// Stage 1 scales directions by length, stage 2 forms end points and differences.
// ----------------------------------------------------------------------------
module ssi_endpoint #(
	parameter int unsigned COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     ld_s1,
	input  logic                     ld_s2,
	input  ssi_pkg::seg_pair_t       pair,
	output logic signed [COORD_WIDTH-1:0] a1x_s2,
	output logic signed [COORD_WIDTH-1:0] a1y_s2,
	output logic signed [COORD_WIDTH:0]   ex_s2,
	output logic signed [COORD_WIDTH:0]   ey_s2,
	output logic signed [COORD_WIDTH:0]   fx_s2,
	output logic signed [COORD_WIDTH:0]   fy_s2,
	output logic signed [COORD_WIDTH:0]   gx_s2,
	output logic signed [COORD_WIDTH:0]   gy_s2
);
	import ssi_pkg::*;

	localparam int unsigned DW = COORD_WIDTH + 1;
	localparam int unsigned PL = IN_WIDTH + LEN_WIDTH + 1;

	logic signed [COORD_WIDTH-1:0] a1x_s1, a1y_s1, b1x_s1, b1y_s1;
	logic signed [PL-1:0]          pax_s1, pay_s1, pbx_s1, pby_s1;
	logic signed [COORD_WIDTH-1:0] a2x, a2y, b2x, b2y;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			a1x_s1 <= COORD_WIDTH'(sat_s(128'(pair.first_start_x), COORD_WIDTH));
			a1y_s1 <= COORD_WIDTH'(sat_s(128'(pair.first_start_y), COORD_WIDTH));
			b1x_s1 <= COORD_WIDTH'(sat_s(128'(pair.second_start_x), COORD_WIDTH));
			b1y_s1 <= COORD_WIDTH'(sat_s(128'(pair.second_start_y), COORD_WIDTH));
			pax_s1 <= PL'(pair.first_dir_x * $signed({1'b0, pair.first_length}));
			pay_s1 <= PL'(pair.first_dir_y * $signed({1'b0, pair.first_length}));
			pbx_s1 <= PL'(pair.second_dir_x * $signed({1'b0, pair.second_length}));
			pby_s1 <= PL'(pair.second_dir_y * $signed({1'b0, pair.second_length}));
		end
	end

	// arithmetic shift floors the scaled step back to Q16.16
	always_comb begin
		a2x = COORD_WIDTH'(sat_s(128'(a1x_s1) + 128'(pax_s1 >>> FRAC_BITS), COORD_WIDTH));
		a2y = COORD_WIDTH'(sat_s(128'(a1y_s1) + 128'(pay_s1 >>> FRAC_BITS), COORD_WIDTH));
		b2x = COORD_WIDTH'(sat_s(128'(b1x_s1) + 128'(pbx_s1 >>> FRAC_BITS), COORD_WIDTH));
		b2y = COORD_WIDTH'(sat_s(128'(b1y_s1) + 128'(pby_s1 >>> FRAC_BITS), COORD_WIDTH));
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			a1x_s2 <= a1x_s1;
			a1y_s2 <= a1y_s1;
			ex_s2  <= DW'(b2x) - DW'(b1x_s1);
			ey_s2  <= DW'(b2y) - DW'(b1y_s1);
			fx_s2  <= DW'(a2x) - DW'(a1x_s1);
			fy_s2  <= DW'(a2y) - DW'(a1y_s1);
			gx_s2  <= DW'(a1x_s1) - DW'(b1x_s1);
			gy_s2  <= DW'(a1y_s1) - DW'(b1y_s1);
		end
	end

endmodule
`default_nettype wire

// File: hdl/ssi_cross.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_cross: cross products
// Stage 3 forms six products, stage 4 the numerators, denominator and signs.
// ----------------------------------------------------------------------------
module ssi_cross #(
	parameter int unsigned COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           ld_s3,
	input  logic                           ld_s4,
	input  logic signed [COORD_WIDTH-1:0]  a1x_s2,
	input  logic signed [COORD_WIDTH-1:0]  a1y_s2,
	input  logic signed [COORD_WIDTH:0]    ex_s2,
	input  logic signed [COORD_WIDTH:0]    ey_s2,
	input  logic signed [COORD_WIDTH:0]    fx_s2,
	input  logic signed [COORD_WIDTH:0]    fy_s2,
	input  logic signed [COORD_WIDTH:0]    gx_s2,
	input  logic signed [COORD_WIDTH:0]    gy_s2,
	output logic [2*COORD_WIDTH+2:0]       mag_a_s4,
	output logic [2*COORD_WIDTH+2:0]       mag_b_s4,
	output logic [2*COORD_WIDTH+2:0]       mag_d_s4,
	output ssi_pkg::ssi_flags_t            flags_s4,
	output logic signed [COORD_WIDTH:0]    fx_s4,
	output logic signed [COORD_WIDTH:0]    fy_s4,
	output logic signed [COORD_WIDTH-1:0]  a1x_s4,
	output logic signed [COORD_WIDTH-1:0]  a1y_s4
);
	import ssi_pkg::*;

	localparam int unsigned DW = COORD_WIDTH + 1;
	localparam int unsigned PW = 2 * DW;
	localparam int unsigned NW = PW + 1;

	logic signed [PW-1:0]          eg_s3, egx_s3, fg_s3, fgx_s3, ef_s3, efy_s3;
	logic signed [DW-1:0]          fx_s3, fy_s3;
	logic signed [COORD_WIDTH-1:0] a1x_s3, a1y_s3;
	logic signed [NW-1:0]          na, nb, den;

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			eg_s3  <= PW'(ex_s2 * gy_s2);
			egx_s3 <= PW'(ey_s2 * gx_s2);
			fg_s3  <= PW'(fx_s2 * gy_s2);
			fgx_s3 <= PW'(fy_s2 * gx_s2);
			ef_s3  <= PW'(ey_s2 * fx_s2);
			efy_s3 <= PW'(ex_s2 * fy_s2);
			fx_s3  <= fx_s2;
			fy_s3  <= fy_s2;
			a1x_s3 <= a1x_s2;
			a1y_s3 <= a1y_s2;
		end
	end

	always_comb begin
		na  = NW'(eg_s3) - NW'(egx_s3);
		nb  = NW'(fg_s3) - NW'(fgx_s3);
		den = NW'(ef_s3) - NW'(efy_s3);
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			mag_a_s4          <= na[NW-1] ? NW'(-na) : NW'(na);
			mag_b_s4          <= nb[NW-1] ? NW'(-nb) : NW'(nb);
			mag_d_s4          <= den[NW-1] ? NW'(-den) : NW'(den);
			flags_s4.den_zero <= (den == '0);
			flags_s4.num_zero <= (na == '0) || (nb == '0);
			flags_s4.neg_a    <= na[NW-1] ^ den[NW-1];
			flags_s4.neg_b    <= nb[NW-1] ^ den[NW-1];
			flags_s4.big_a    <= 1'b0;
			flags_s4.big_b    <= 1'b0;
			fx_s4             <= fx_s3;
			fy_s4             <= fy_s3;
			a1x_s4            <= a1x_s3;
			a1y_s4            <= a1y_s3;
		end
	end

endmodule
`default_nettype wire

// File: hdl/ssi_div_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_div_stage: one stage of the restoring quotient divider
// Resolves quotient bits HI down to LO for both quotients; the top stage
// also flags quotients that reach two or more.
// ----------------------------------------------------------------------------
module ssi_div_stage #(
	parameter int unsigned COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF,
	parameter int unsigned HI          = ssi_pkg::QUOT_BITS - 1,
	parameter int unsigned LO          = ssi_pkg::QUOT_BITS - ssi_pkg::DIV_STEPS
) (
	input  logic                                     clk,
	input  logic                                     ld,
	input  logic [2*COORD_WIDTH+2+ssi_pkg::FRAC_BITS:0] rem_a_i,
	input  logic [2*COORD_WIDTH+2+ssi_pkg::FRAC_BITS:0] rem_b_i,
	input  logic [ssi_pkg::QUOT_BITS-1:0]            q_a_i,
	input  logic [ssi_pkg::QUOT_BITS-1:0]            q_b_i,
	input  logic [2*COORD_WIDTH+2:0]                 mag_d_i,
	input  ssi_pkg::ssi_flags_t                      flags_i,
	input  logic signed [COORD_WIDTH:0]              fx_i,
	input  logic signed [COORD_WIDTH:0]              fy_i,
	input  logic signed [COORD_WIDTH-1:0]            a1x_i,
	input  logic signed [COORD_WIDTH-1:0]            a1y_i,
	output logic [2*COORD_WIDTH+2+ssi_pkg::FRAC_BITS:0] rem_a_s,
	output logic [2*COORD_WIDTH+2+ssi_pkg::FRAC_BITS:0] rem_b_s,
	output logic [ssi_pkg::QUOT_BITS-1:0]            q_a_s,
	output logic [ssi_pkg::QUOT_BITS-1:0]            q_b_s,
	output logic [2*COORD_WIDTH+2:0]                 mag_d_s,
	output ssi_pkg::ssi_flags_t                      flags_s,
	output logic signed [COORD_WIDTH:0]              fx_s,
	output logic signed [COORD_WIDTH:0]              fy_s,
	output logic signed [COORD_WIDTH-1:0]            a1x_s,
	output logic signed [COORD_WIDTH-1:0]            a1y_s
);
	import ssi_pkg::*;

	localparam int unsigned NW = 2 * COORD_WIDTH + 3;
	localparam int unsigned RW = NW + FRAC_BITS;

	logic [RW-1:0]        ra, rb, t;
	logic [QUOT_BITS-1:0] qa, qb;
	ssi_flags_t           fl;

	always_comb begin
		ra = rem_a_i;
		rb = rem_b_i;
		qa = q_a_i;
		qb = q_b_i;
		fl = flags_i;
		t  = '0;
		// a quotient of two or more never fits the unit interval
		if (HI == QUOT_BITS - 1) begin
			fl.big_a = ({1'b0, rem_a_i} >= {mag_d_i, {QUOT_BITS{1'b0}}});
			fl.big_b = ({1'b0, rem_b_i} >= {mag_d_i, {QUOT_BITS{1'b0}}});
		end
		for (int i = HI; i >= int'(LO); i--) begin
			t = RW'(mag_d_i) << i;
			if (ra >= t) begin
				ra    = ra - t;
				qa[i] = 1'b1;
			end
			if (rb >= t) begin
				rb    = rb - t;
				qb[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			rem_a_s <= ra;
			rem_b_s <= rb;
			q_a_s   <= qa;
			q_b_s   <= qb;
			mag_d_s <= mag_d_i;
			flags_s <= fl;
			fx_s    <= fx_i;
			fy_s    <= fy_i;
			a1x_s   <= a1x_i;
			a1y_s   <= a1y_i;
		end
	end

endmodule
`default_nettype wire

// File: hdl/ssi_lerp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_lerp: range check and point interpolation
// Stage 11 classifies the hit and scales the first edge, stage 12 adds the
// start point, saturates and holds the result beat.
// ----------------------------------------------------------------------------
module ssi_lerp #(
	parameter int unsigned COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           ld_s11,
	input  logic                           ld_s12,
	input  logic [ssi_pkg::QUOT_BITS-1:0]  q_a_i,
	input  logic [ssi_pkg::QUOT_BITS-1:0]  q_b_i,
	input  ssi_pkg::ssi_flags_t            flags_i,
	input  logic signed [COORD_WIDTH:0]    fx_i,
	input  logic signed [COORD_WIDTH:0]    fy_i,
	input  logic signed [COORD_WIDTH-1:0]  a1x_i,
	input  logic signed [COORD_WIDTH-1:0]  a1y_i,
	output ssi_pkg::hit_kind_t             hit_kind_s12,
	output logic signed [ssi_pkg::OUT_WIDTH-1:0] hit_x_s12,
	output logic signed [ssi_pkg::OUT_WIDTH-1:0] hit_y_s12
);
	import ssi_pkg::*;

	localparam int unsigned PXW = COORD_WIDTH + 1 + QUOT_BITS + 1;

	logic                          ok_a, ok_b;
	hit_kind_t                     kind;
	hit_kind_t                     kind_s11;
	logic signed [PXW-1:0]         px_s11, py_s11;
	logic signed [COORD_WIDTH-1:0] a1x_s11, a1y_s11;
	logic signed [127:0]           sx, sy;

	// a quotient that truncates to zero passes whatever its sign
	always_comb begin
		ok_a = !flags_i.big_a && ((q_a_i == '0) ||
			(!flags_i.neg_a && (q_a_i <= QUOT_BITS'(QUOT_ONE))));
		ok_b = !flags_i.big_b && ((q_b_i == '0) ||
			(!flags_i.neg_b && (q_b_i <= QUOT_BITS'(QUOT_ONE))));
		if (flags_i.den_zero) begin
			kind = flags_i.num_zero ? HIT_OVERLAP : HIT_NONE;
		end else begin
			kind = (ok_a && ok_b) ? HIT_POINT : HIT_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s11) begin
			kind_s11 <= kind;
			px_s11   <= PXW'(fx_i * $signed({1'b0, q_a_i}));
			py_s11   <= PXW'(fy_i * $signed({1'b0, q_a_i}));
			a1x_s11  <= a1x_i;
			a1y_s11  <= a1y_i;
		end
	end

	always_comb begin
		sx = sat_s(128'(a1x_s11) + 128'(px_s11 >>> FRAC_BITS), OUT_WIDTH);
		sy = sat_s(128'(a1y_s11) + 128'(py_s11 >>> FRAC_BITS), OUT_WIDTH);
	end

	always_ff @(posedge clk) begin
		if (ld_s12) begin
			hit_kind_s12 <= kind_s11;
			hit_x_s12    <= (kind_s11 == HIT_POINT) ? OUT_WIDTH'(sx) : '0;
			hit_y_s12    <= (kind_s11 == HIT_POINT) ? OUT_WIDTH'(sy) : '0;
		end
	end

endmodule
`default_nettype wire

// File: hdl/segment_segment_intersect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_segment_intersect: 2D segment pair intersection, Q16.16
// Builds both end points, forms the cross products, divides to a unit
// parameter and reports a point, an overlap or no hit.
// ----------------------------------------------------------------------------
//
//  channel  direction  beat contents
//  -------  ---------  ---------------------------------------------------
//  pair     in         two segments: start, direction, length (Q16.16)
//  hit      out        hit_kind, hit_x, hit_y (Q16.16)
//
// Twelve register stages; one beat enters per cycle unless a stall on hit
// backs up to the first stage. The divider resolves three quotient bits
// per stage (two in the last) over six stages and sets the depth.
// Reset clears only the stage valid bits; no data is reset.
// Each stage loads when it is empty or the stage after it moves, so a
// stall on hit holds the full stages up to the first empty one, and empty stages keep filling.
//
module segment_segment_intersect #(
	parameter int unsigned COORD_WIDTH = ssi_pkg::COORD_WIDTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	ssi_pair_if.sink  pair,
	ssi_hit_if.source hit
);
	import ssi_pkg::*;

	localparam int unsigned W  = COORD_WIDTH;
	localparam int unsigned NW = 2 * W + 3;
	localparam int unsigned RW = NW + FRAC_BITS;
	localparam int unsigned LS = 4 + DIV_STAGES;

	logic [NUM_STAGES-1:0] v_q;
	logic [NUM_STAGES:0]   ld;
	seg_pair_t             pair_d;

	// stage 2 -> stage 3
	logic signed [W-1:0] a1x_s2, a1y_s2;
	logic signed [W:0]   ex_s2, ey_s2, fx_s2, fy_s2, gx_s2, gy_s2;

	// divider chain, index 0 fed by stage 4
	logic [RW-1:0]        rem_a [DIV_STAGES+1];
	logic [RW-1:0]        rem_b [DIV_STAGES+1];
	logic [QUOT_BITS-1:0] q_a   [DIV_STAGES+1];
	logic [QUOT_BITS-1:0] q_b   [DIV_STAGES+1];
	logic [NW-1:0]        mag_d [DIV_STAGES+1];
	ssi_flags_t           flags [DIV_STAGES+1];
	logic signed [W:0]    fx    [DIV_STAGES+1];
	logic signed [W:0]    fy    [DIV_STAGES+1];
	logic signed [W-1:0]  a1x   [DIV_STAGES+1];
	logic signed [W-1:0]  a1y   [DIV_STAGES+1];
	logic [NW-1:0]        mag_a_s4, mag_b_s4;

	hit_kind_t              hit_kind_s12;
	logic signed [OUT_WIDTH-1:0] hit_x_s12, hit_y_s12;

	// advance a stage when it is empty or its successor advances
	always_comb begin
		ld[NUM_STAGES] = hit.ready;
		for (int k = NUM_STAGES - 1; k >= 0; k--) begin
			ld[k] = !v_q[k] || ld[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (ld[0]) begin
				v_q[0] <= pair.valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (ld[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign pair.ready = ld[0];

	always_comb begin
		pair_d.first_start_x  = pair.first_start_x;
		pair_d.first_start_y  = pair.first_start_y;
		pair_d.first_dir_x    = pair.first_dir_x;
		pair_d.first_dir_y    = pair.first_dir_y;
		pair_d.first_length   = pair.first_length;
		pair_d.second_start_x = pair.second_start_x;
		pair_d.second_start_y = pair.second_start_y;
		pair_d.second_dir_x   = pair.second_dir_x;
		pair_d.second_dir_y   = pair.second_dir_y;
		pair_d.second_length  = pair.second_length;
	end

	// stages 1-2: end points and edge vectors
	ssi_endpoint #(.COORD_WIDTH(W)) u_endpoint (
		.clk    (clk),
		.ld_s1  (ld[0]),
		.ld_s2  (ld[1]),
		.pair   (pair_d),
		.a1x_s2 (a1x_s2),
		.a1y_s2 (a1y_s2),
		.ex_s2  (ex_s2),
		.ey_s2  (ey_s2),
		.fx_s2  (fx_s2),
		.fy_s2  (fy_s2),
		.gx_s2  (gx_s2),
		.gy_s2  (gy_s2)
	);

	// stages 3-4: numerators, denominator, magnitudes and signs
	ssi_cross #(.COORD_WIDTH(W)) u_cross (
		.clk      (clk),
		.ld_s3    (ld[2]),
		.ld_s4    (ld[3]),
		.a1x_s2   (a1x_s2),
		.a1y_s2   (a1y_s2),
		.ex_s2    (ex_s2),
		.ey_s2    (ey_s2),
		.fx_s2    (fx_s2),
		.fy_s2    (fy_s2),
		.gx_s2    (gx_s2),
		.gy_s2    (gy_s2),
		.mag_a_s4 (mag_a_s4),
		.mag_b_s4 (mag_b_s4),
		.mag_d_s4 (mag_d[0]),
		.flags_s4 (flags[0]),
		.fx_s4    (fx[0]),
		.fy_s4    (fy[0]),
		.a1x_s4   (a1x[0]),
		.a1y_s4   (a1y[0])
	);

	// numerators scaled by 2^16 seed the partial remainders
	assign rem_a[0] = {mag_a_s4, {FRAC_BITS{1'b0}}};
	assign rem_b[0] = {mag_b_s4, {FRAC_BITS{1'b0}}};
	assign q_a[0]   = '0;
	assign q_b[0]   = '0;

	// stages 5-10: quotient bits, most significant first
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		localparam int HI_B = QUOT_BITS - 1 - g * DIV_STEPS;
		localparam int LO_B = (HI_B - int'(DIV_STEPS) + 1 > 0) ?
			HI_B - int'(DIV_STEPS) + 1 : 0;

		ssi_div_stage #(
			.COORD_WIDTH (W),
			.HI          (HI_B),
			.LO          (LO_B)
		) u_div (
			.clk     (clk),
			.ld      (ld[4+g]),
			.rem_a_i (rem_a[g]),
			.rem_b_i (rem_b[g]),
			.q_a_i   (q_a[g]),
			.q_b_i   (q_b[g]),
			.mag_d_i (mag_d[g]),
			.flags_i (flags[g]),
			.fx_i    (fx[g]),
			.fy_i    (fy[g]),
			.a1x_i   (a1x[g]),
			.a1y_i   (a1y[g]),
			.rem_a_s (rem_a[g+1]),
			.rem_b_s (rem_b[g+1]),
			.q_a_s   (q_a[g+1]),
			.q_b_s   (q_b[g+1]),
			.mag_d_s (mag_d[g+1]),
			.flags_s (flags[g+1]),
			.fx_s    (fx[g+1]),
			.fy_s    (fy[g+1]),
			.a1x_s   (a1x[g+1]),
			.a1y_s   (a1y[g+1])
		);
	end

	// stages 11-12: classify, interpolate, output register
	ssi_lerp #(.COORD_WIDTH(W)) u_lerp (
		.clk          (clk),
		.ld_s11       (ld[LS]),
		.ld_s12       (ld[LS+1]),
		.q_a_i        (q_a[DIV_STAGES]),
		.q_b_i        (q_b[DIV_STAGES]),
		.flags_i      (flags[DIV_STAGES]),
		.fx_i         (fx[DIV_STAGES]),
		.fy_i         (fy[DIV_STAGES]),
		.a1x_i        (a1x[DIV_STAGES]),
		.a1y_i        (a1y[DIV_STAGES]),
		.hit_kind_s12 (hit_kind_s12),
		.hit_x_s12    (hit_x_s12),
		.hit_y_s12    (hit_y_s12)
	);

	assign hit.valid    = v_q[NUM_STAGES-1];
	assign hit.hit_kind = hit_kind_s12;
	assign hit.hit_x    = hit_x_s12;
	assign hit.hit_y    = hit_y_s12;

endmodule
`default_nettype wire

// File: hdl/ssi_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_checker: port-level checks for the segment intersection block
// Watches the hit channel and the ready path; bound to the top level.
// ----------------------------------------------------------------------------
module ssi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  hit_kind,
	input logic [31:0] hit_x,
	input logic [31:0] hit_y
);
	import ssi_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit_kind) &&
		$stable(hit_x) && $stable(hit_y))
		else $error("hit beat changed under stall");

	// no code beyond overlap
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hit_kind == HIT_NONE) || (hit_kind == HIT_POINT) ||
		(hit_kind == HIT_OVERLAP))
		else $error("illegal hit kind");

	// coordinates are zero unless a point is reported
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (hit_kind != HIT_POINT) |-> (hit_x == '0) && (hit_y == '0))
		else $error("coordinates set without a point hit");

	// a ready sink lets the whole pipe advance
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is ready");

endmodule

bind segment_segment_intersect ssi_checker u_ssi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pair.ready),
	.out_valid (hit.valid),
	.out_ready (hit.ready),
	.hit_kind  (hit.hit_kind),
	.hit_x     (hit.hit_x),
	.hit_y     (hit.hit_y)
);
`default_nettype wire
